/* rtl/dbg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbg_pkg
// Shared widths, codes, types and the bucket classifier for the degree
// bucket grouping block.
// ----------------------------------------------------------------------------
package dbg_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int BUCKETS      = 8;

  localparam int DATA_W    = 32;
  localparam int ID_W      = 12;
  localparam int ADDR_W    = $clog2(MAX_VERTICES);
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int DIV_CNT_W = $clog2(DATA_W + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MODE = 1'd1;

  typedef logic [BUCKETS-1:0][DATA_W-1:0] thr_arr_t;
  typedef logic [BUCKETS-1:0][CNT_W-1:0]  cnt_arr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_THR,
    ST_PASS1,
    ST_PFX,
    ST_PASS2
  } state_t;

  typedef struct packed {
    logic busy;
    logic div_start;
    logic div_step;
    logic thr_load;
    logic scan_clear;
    logic scan_run;
    logic pass2;
    logic pfx_load;
    logic set_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic last_load;
    logic div_done;
    logic scan_done;
    logic pipe_busy;
    logic map_ready;
  } dp_stat_t;

  // first bucket whose threshold covers the degree
  function automatic logic [BKT_W-1:0] bucket_of(input logic [DATA_W-1:0] deg,
                                                 input thr_arr_t thr);
    logic [BKT_W-1:0] b;
    b = BKT_W'(BUCKETS - 1);
    for (int j = BUCKETS - 1; j >= 0; j--) begin
      if (deg <= thr[j]) begin
        b = BKT_W'(j);
      end
    end
    return b;
  endfunction

endpackage

/* rtl/dbg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/dbg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbg_ctrl
// Sequencer for the grouping: divide, thresholds, count pass, prefix,
// id assignment pass.
// ----------------------------------------------------------------------------
module dbg_ctrl import dbg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.busy  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (stat.last_load) begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_THR;
        end
      end
      ST_THR: begin
        cmd.thr_load   = 1'b1;
        cmd.scan_clear = 1'b1;
        state_nxt      = ST_PASS1;
      end
      ST_PASS1: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done && !stat.pipe_busy) begin
          state_nxt = ST_PFX;
        end
      end
      ST_PFX: begin
        cmd.pfx_load   = 1'b1;
        cmd.scan_clear = 1'b1;
        state_nxt      = ST_PASS2;
      end
      ST_PASS2: begin
        cmd.scan_run = 1'b1;
        cmd.pass2    = 1'b1;
        if (stat.scan_done && !stat.pipe_busy) begin
          cmd.set_ready = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dbg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbg_datapath
// Degree and new-id stores, serial divider, thresholds, bucket counters,
// scan pipeline, query path and output register.
// ----------------------------------------------------------------------------
module dbg_datapath import dbg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [DATA_W-1:0]    in_degree,
  input  logic                 in_last,
  input  logic [11:0]          in_vertex_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      out_new_id,
  output logic                 out_valid_res,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic [DATA_W-1:0]    edge_count_r;
  logic                 mode_r;
  logic [CNT_W-1:0]     count_r;
  logic                 ready_r;

  logic [CNT_W-1:0]     rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  thr_arr_t             thr_r, thr_nxt;
  cnt_arr_t             bcnt_r;
  cnt_arr_t             start_r, pfx_nxt;

  logic [CNT_W-1:0]     scan_cnt_r;
  logic                 pv_r;
  logic [ADDR_W-1:0]    pidx_r;

  logic                 pend_r;
  logic                 pend_ok_r;
  logic                 out_valid_r;
  logic [ID_W-1:0]      out_new_id_r;
  logic                 out_valid_res_r;

  logic                 in_acc, ld_acc, q_acc, ld_room, scan_done, ge;
  logic [CNT_W-1:0]     ld_base, acc;
  logic [CNT_W:0]       trial, diff;
  logic [DATA_W-1:0]    deg_rd;
  logic [ID_W-1:0]      nid_rd;
  logic [BKT_W-1:0]     bkt;

  // handshake
  assign in_stall = cmd.busy |
                    ((in_operation == OP_QUERY) & (pend_r | (out_valid_r & out_stall)));
  assign in_acc   = in_valid & ~in_stall;
  assign ld_acc   = in_acc & (in_operation == OP_LOAD);
  assign q_acc    = in_acc & (in_operation == OP_QUERY);

  // a load after a finished grouping starts a new graph
  assign ld_base  = ready_r ? '0 : count_r;
  assign ld_room  = ld_base < CNT_W'(MAX_VERTICES);

  assign scan_done = (scan_cnt_r == count_r);

  assign stat.last_load = ld_acc & in_last;
  assign stat.div_done  = (div_cnt_r == DIV_CNT_W'(DATA_W));
  assign stat.scan_done = scan_done;
  assign stat.pipe_busy = pv_r;
  assign stat.map_ready = ready_r;

  dbg_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk     (clk),
    .we      (ld_acc & ld_room),
    .wr_addr (ld_base[ADDR_W-1:0]),
    .wr_data (in_degree),
    .rd_addr (scan_cnt_r[ADDR_W-1:0]),
    .rd_data (deg_rd)
  );

  assign bkt = bucket_of(deg_rd, thr_r);

  dbg_ram #(.WIDTH(ID_W), .DEPTH(MAX_VERTICES)) u_nid_ram (
    .clk     (clk),
    .we      (pv_r & cmd.pass2),
    .wr_addr (pidx_r),
    .wr_data (ID_W'(start_r[bkt])),
    .rd_addr (ADDR_W'(in_vertex_index)),
    .rd_data (nid_rd)
  );

  // restoring divider step: edge_count / count
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign ge    = trial >= {1'b0, count_r};
  assign diff  = trial - {1'b0, count_r};

  always_comb begin
    for (int j = 0; j < BUCKETS; j++) begin
      if (j == 0) begin
        thr_nxt[j] = mode_r ? quo_r : (quo_r >> 1);
      end else if (mode_r || (j == BUCKETS - 1)) begin
        thr_nxt[j] = ALL_ONES;
      end else begin
        thr_nxt[j] = quo_r << ((j - 1) % 16);
      end
    end
  end

  // higher buckets take the low ids
  always_comb begin
    acc = '0;
    for (int j = BUCKETS - 1; j >= 0; j--) begin
      pfx_nxt[j] = acc;
      acc        = acc + bcnt_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r    <= '0;
      mode_r          <= 1'b0;
      count_r         <= '0;
      ready_r         <= 1'b0;
      div_cnt_r       <= '0;
      bcnt_r          <= '0;
      scan_cnt_r      <= '0;
      pv_r            <= 1'b0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_EDGE_COUNT: edge_count_r <= cfg_data;
          CFG_GROUP_MODE: mode_r       <= cfg_data[0];
          default: ;
        endcase
      end

      if (ld_acc) begin
        ready_r <= 1'b0;
        count_r <= ld_room ? ld_base + CNT_W'(1) : ld_base;
      end else if (cmd.set_ready) begin
        ready_r <= 1'b1;
      end

      if (cmd.div_start) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step && !stat.div_done) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end

      if (cmd.scan_clear) begin
        scan_cnt_r <= '0;
        pv_r       <= 1'b0;
      end else begin
        pv_r <= cmd.scan_run & ~scan_done;
        if (cmd.scan_run && !scan_done) begin
          scan_cnt_r <= scan_cnt_r + CNT_W'(1);
        end
      end

      if (cmd.thr_load) begin
        bcnt_r <= '0;
      end else if (pv_r && !cmd.pass2) begin
        bcnt_r[bkt] <= bcnt_r[bkt] + CNT_W'(1);
      end

      pend_r <= q_acc;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= scan_cnt_r[ADDR_W-1:0];
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= edge_count_r;
    end else if (cmd.div_step && !stat.div_done) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
    if (cmd.thr_load) begin
      thr_r <= thr_nxt;
    end
    if (cmd.pfx_load) begin
      start_r <= pfx_nxt;
    end else if (pv_r && cmd.pass2) begin
      start_r[bkt] <= start_r[bkt] + CNT_W'(1);
    end
    if (q_acc) begin
      pend_ok_r <= ready_r & (CNT_W'(in_vertex_index) < count_r);
    end
    if (pend_r) begin
      out_new_id_r    <= pend_ok_r ? nid_rd : '0;
      out_valid_res_r <= pend_ok_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_id    = out_new_id_r;
  assign out_valid_res = out_valid_res_r;

endmodule

/* rtl/degree_bucket_grouping.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_bucket_grouping
// Degree based grouping reorder: loads vertex degrees, buckets them against
// thresholds derived from the average degree and answers new-id queries.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      valid / stall      operation, degree, last, vertex_index
//  out_     output     valid / stall      new_id, valid_res
//  cfg_     input      valid / ready      index, data (edge_count, group_mode)
//
//  A load is accepted whenever the block is not grouping; a query result is
//  registered in the new-id RAM read and then in the output register.
//  A load flagged last starts the grouping: a 32-step serial divider, then
//  two scans of the degree RAM. Input stalls during grouping; a query
//  stalls while a result is pending or the output is held by out_stall.
//  Synchronous active-low reset clears control state; stores need no clearing.
// ----------------------------------------------------------------------------
module degree_bucket_grouping import dbg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [DATA_W-1:0]    in_degree,
  input  logic                 in_last,
  input  logic [11:0]          in_vertex_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      out_new_id,
  output logic                 out_valid_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  dbg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  dbg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_degree       (in_degree),
    .in_last         (in_last),
    .in_vertex_index (in_vertex_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_id      (out_new_id),
    .out_valid_res   (out_valid_res),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !cmd.busy)
    else $error("item accepted during grouping");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.busy |-> !stat.map_ready)
    else $error("mapping ready while grouping");

  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_QUERY) |=> ##1 out_valid)
    else $error("query result missing");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_new_id == '0))
    else $error("invalid result with nonzero id");
`endif

endmodule

/* dv/degree_bucket_grouping_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_bucket_grouping_checker
// Follows register writes, degree loads and id queries on the block's
// channels. Keeps its own bucket grouping of the loaded graph and compares
// every returned id item, in order, against the answer it predicts.
// ----------------------------------------------------------------------------
module degree_bucket_grouping_checker import dbg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_operation,
  input  logic [DATA_W-1:0]    in_degree,
  input  logic                 in_last,
  input  logic [11:0]          in_vertex_index,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ID_W-1:0]      out_new_id,
  input  logic                 out_valid_res,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    logic [ID_W-1:0] new_id;
    logic            valid_res;
  } id_answer_t;

  logic [DATA_W-1:0] degrees [MAX_VERTICES];
  int unsigned       ids     [MAX_VERTICES];
  logic [DATA_W-1:0] limits  [BUCKETS];
  int unsigned       bucket_total;
  int unsigned       held;
  logic              map_ready;
  logic [DATA_W-1:0] edge_total;
  logic              two_way;
  id_answer_t        id_answers[$];
  id_answer_t        answer;

  function automatic int bucket_of_degree(input logic [DATA_W-1:0] d);
    int b;
    b = int'(bucket_total) - 1;
    for (int j = int'(bucket_total) - 1; j >= 0; j--) begin
      if (d <= limits[j]) begin
        b = j;
      end
    end
    return b;
  endfunction

  function automatic void rebuild_id_map();
    logic [DATA_W-1:0] avg;
    int unsigned       per_bucket [BUCKETS];
    int unsigned       next_id    [BUCKETS];
    int unsigned       base;
    int                b;
    avg = (held != 0) ? edge_total / DATA_W'(held) : '0;
    if (two_way) begin
      bucket_total = 2;
      limits[0] = avg;
      limits[1] = ALL_ONES;
    end else begin
      bucket_total = BUCKETS;
      limits[0] = avg >> 1;
      for (int j = 1; j < BUCKETS; j++) begin
        limits[j] = avg << (j - 1);
      end
      limits[BUCKETS-1] = ALL_ONES;
    end
    for (int j = 0; j < BUCKETS; j++) begin
      per_bucket[j] = 0;
    end
    for (int unsigned v = 0; v < held; v++) begin
      per_bucket[bucket_of_degree(degrees[v])]++;
    end
    // highest bucket takes the lowest ids
    base = 0;
    for (int j = int'(bucket_total) - 1; j >= 0; j--) begin
      next_id[j] = base;
      base += per_bucket[j];
    end
    for (int unsigned v = 0; v < held; v++) begin
      b = bucket_of_degree(degrees[v]);
      ids[v] = next_id[b];
      next_id[b]++;
    end
    map_ready = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_total = '0;
      two_way    = 1'b0;
      held       = 0;
      map_ready  = 1'b0;
      id_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EDGE_COUNT: edge_total = cfg_data;
          CFG_GROUP_MODE: two_way = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_operation == OP_LOAD) begin
          // a load after grouping opens a new graph
          if (map_ready) begin
            map_ready = 1'b0;
            held      = 0;
          end
          if (held < MAX_VERTICES) begin
            degrees[held] = in_degree;
            held++;
          end
          if (in_last) begin
            rebuild_id_map();
          end
        end else begin
          if (map_ready && in_vertex_index < held) begin
            answer.new_id    = ID_W'(ids[in_vertex_index]);
            answer.valid_res = 1'b1;
          end else begin
            answer.new_id    = '0;
            answer.valid_res = 1'b0;
          end
          id_answers = {id_answers, answer};
        end
      end
      if (out_valid && !out_stall) begin
        if (id_answers.size() == 0) begin
          $error("id item with no query outstanding: new_id %0d valid_res %0d",
                 out_new_id, out_valid_res);
          fail_count++;
        end else begin
          answer = id_answers.pop_front();
          if (out_new_id !== answer.new_id) begin
            $error("new_id mismatch: expected %0d, got %0d", answer.new_id, out_new_id);
            fail_count++;
          end
          if (out_valid_res !== answer.valid_res) begin
            $error("valid_res mismatch: expected %0d, got %0d",
                   answer.valid_res, out_valid_res);
            fail_count++;
          end
        end
      end
    end
    pending_count = id_answers.size();
  end

endmodule

/* dv/tb_degree_bucket_grouping.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_degree_bucket_grouping
// Drives degree loads, id queries and register writes into the grouping
// block: a directed opening (early queries, extreme degrees and edge counts,
// both modes), then random graphs under three idle patterns. The checker
// beside the block scores every id item.
// ----------------------------------------------------------------------------
module tb_degree_bucket_grouping;
  import dbg_pkg::*;

  localparam int QUIET_LIMIT = 40000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [DATA_W-1:0]    in_degree;
  logic                 in_last;
  logic [11:0]          in_vertex_index;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ID_W-1:0]      out_new_id;
  logic                 out_valid_res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int          fail_count;
  int          pending_count;
  int          send_idle = 36;
  int          recv_idle = 54;
  logic [31:0] cur_edges = '0;
  int          last_size = 0;
  int          sent = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  degree_bucket_grouping i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_degree       (in_degree),
    .in_last         (in_last),
    .in_vertex_index (in_vertex_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_id      (out_new_id),
    .out_valid_res   (out_valid_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  degree_bucket_grouping_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_degree       (in_degree),
    .in_last         (in_last),
    .in_vertex_index (in_vertex_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_id      (out_new_id),
    .out_valid_res   (out_valid_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_item(input logic op, input logic [DATA_W-1:0] d, input logic lst,
                          input logic [11:0] idx);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_degree       <= d;
    in_last         <= lst;
    in_vertex_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic load(input logic [DATA_W-1:0] d, input logic lst);
    put_item(OP_LOAD, d, lst, 12'($urandom));
  endtask

  task automatic query(input logic [11:0] idx);
    put_item(OP_QUERY, $urandom, 1'($urandom), idx);
  endtask

  // drain all id items, then cover a grouping pass that has no item to show for it
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (2 * last_size + 100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [DATA_W-1:0] e_val, input logic mode);
    settle();
    write_reg(CFG_EDGE_COUNT, e_val);
    write_reg(CFG_GROUP_MODE, DATA_W'(mode));
    cfg_valid <= 1'b0;
    cur_edges = e_val;
  endtask

  function automatic logic [11:0] pick_index(input int n);
    case ($urandom_range(9))
      8: return (n < 4096) ? 12'($urandom_range(4095, n)) : 12'($urandom);
      9: return 12'($urandom);
      default: return 12'($urandom_range(n - 1));
    endcase
  endfunction

  task automatic run_graph(input int n, input int q);
    logic [DATA_W-1:0] avg;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] d;
    int                held_n;
    int                s;
    held_n = (n > MAX_VERTICES) ? MAX_VERTICES : n;
    avg = cur_edges / DATA_W'(held_n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        query(pick_index(held_n));
      end
      case ($urandom_range(5))
        0: d = $urandom;
        1: d = $urandom_range(15);
        2, 3: begin
          // land on or next to a bucket threshold
          s = $urandom_range(7);
          base = (s == 0) ? avg >> 1 : (s == 7) ? ALL_ONES : avg << (s - 1);
          d = base + $urandom_range(2) - 1;
        end
        4: d = $urandom_range(1) ? ALL_ONES : '0;
        default: d = avg;
      endcase
      load(d, k == n - 1);
    end
    last_size = held_n;
    repeat (q) query(pick_index(held_n));
  endtask

  initial begin
    int          n;
    int          goal;
    logic [31:0] e_val;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_LOAD;
    in_degree       = '0;
    in_last         = 1'b0;
    in_vertex_index = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_EDGE_COUNT;
    cfg_data        = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // queries before any graph exists
    query(12'd0);
    query(12'hFFF);

    set_regs(ALL_ONES, 1'b0);
    load('0, 1'b0);
    query(12'd0);
    load(ALL_ONES, 1'b0);
    load(32'd1, 1'b0);
    load(32'h4000_0000, 1'b1);
    last_size = 4;
    for (int i = 0; i < 5; i++) begin
      query(12'(i));
    end
    query(12'hFFF);

    set_regs('0, 1'b1);
    load('0, 1'b0);
    load(ALL_ONES, 1'b1);
    last_size = 2;
    query(12'd0);
    query(12'd1);
    query(12'd2);

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 36 : (p == 1) ? 54 : 0;
      recv_idle = (p == 0) ? 54 : (p == 1) ? 36 : 0;
      goal = sent + 500;
      while (sent < goal) begin
        case ($urandom_range(99)) inside
          [0:84]:  n = $urandom_range(24, 1);
          [85:96]: n = $urandom_range(200, 25);
          default: n = $urandom_range(1000, 201);
        endcase
        if ($urandom_range(1) == 0) begin
          case ($urandom_range(5))
            0: e_val = '0;
            1: e_val = ALL_ONES;
            2: e_val = $urandom;
            default: e_val = 32'(n) * $urandom_range(40);
          endcase
          set_regs(e_val, 1'($urandom_range(1)));
        end
        run_graph(n, $urandom_range(12, 2));
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
